[hw/rtl/gbfw_pkg.sv]
// Package for the 2bpp block framebuffer writer.
// Holds the command and result words and the action codes; no dependencies.
package gbfw_pkg;

    // Action codes carried in a command word
    localparam logic [1:0] ACT_WRITE  = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_WINDOW = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_PANEL_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_PANEL_HEIGHT = 2'd1;

    // Reset values of the configuration registers
    localparam logic [8:0] PANEL_WIDTH_RST  = 9'd300;
    localparam logic [8:0] PANEL_HEIGHT_RST = 9'd400;

    // Command word
    typedef struct packed {
        logic [1:0]         action;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [1:0]         gray;
        logic [8:0]         rect_width;
        logic [8:0]         rect_height;
        logic [7:0]         read_row;
        logic [7:0]         read_column;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic [7:0] read_data;
        logic       window_valid;
        logic [7:0] column_start;
        logic [7:0] column_end;
        logic [7:0] row_start;
        logic [7:0] row_end;
    } t_out_word;

    // Controller address window
    typedef struct packed {
        logic       valid;
        logic [7:0] column_start;
        logic [7:0] column_end;
        logic [7:0] row_start;
        logic [7:0] row_end;
    } t_win_addr;

endpackage

[hw/rtl/gbfw_window.sv]
// Window address unit: logical rectangle to controller column/row addresses.
// Depends on gbfw_pkg (t_in_word, t_win_addr). One register stage.
module gbfw_window (
    input  logic                i_clk,
    input  logic                i_load,
    input  gbfw_pkg::t_in_word  i_item,
    output gbfw_pkg::t_win_addr o_win
);

    // x / 6 is (x >> 1) / 3; n / 3 == (n * 43691) >> 17 for any n below 2^17
    localparam logic [15:0] DIV3_MUL   = 16'hAAAB;
    localparam int          DIV3_SHIFT = 17;
    localparam logic [7:0]  COL_OFFSET = 8'd5;

    logic        n_valid;
    logic [15:0] n_x_end;
    logic [15:0] n_y_end;

    logic        r_valid;
    logic [30:0] r_prod_start;
    logic [30:0] r_prod_end;
    logic [7:0]  r_row_start;
    logic [7:0]  r_row_end;

    // Validity and far corners
    always_comb begin
        n_valid = (i_item.rect_width != 9'd0) && (i_item.rect_height != 9'd0)
                  && !i_item.pos_x[15] && !i_item.pos_y[15];
        n_x_end = i_item.pos_x + 16'(i_item.rect_width) - 16'd1;
        n_y_end = i_item.pos_y + 16'(i_item.rect_height) - 16'd1;
    end

    // Reciprocal multiplies and row halving, registered
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_valid      <= n_valid;
            r_prod_start <= 31'(i_item.pos_x[15:1]) * 31'(DIV3_MUL);
            r_prod_end   <= 31'(n_x_end[15:1]) * 31'(DIV3_MUL);
            r_row_start  <= i_item.pos_y[8:1];
            r_row_end    <= n_y_end[8:1];
        end
    end

    // Offset columns; an invalid window reports all zeros
    always_comb begin
        o_win.valid        = r_valid;
        o_win.column_start = r_valid ? 8'(r_prod_start[30:DIV3_SHIFT]) + COL_OFFSET : 8'd0;
        o_win.column_end   = r_valid ? 8'(r_prod_end[30:DIV3_SHIFT]) + COL_OFFSET : 8'd0;
        o_win.row_start    = r_valid ? r_row_start : 8'd0;
        o_win.row_end      = r_valid ? r_row_end : 8'd0;
    end

endmodule

[hw/rtl/gray2_block_framebuffer_writer_core.sv]
// Top level of the 2bpp block framebuffer writer; depends on gbfw_pkg and gbfw_window.
// Each command passes through accept, memory lookup and modify/write-back; a new command
// is taken only after the last one is done, set by the single store read-modify-write.
// Read and window commands strobe a result word after modify/write-back; it cannot stall.
// After reset the store is cleared, one byte a cycle, over all STORE_COLUMNS*STORE_ROWS
// bytes (30000 at defaults) with busy high; configuration writes are taken throughout.
module gray2_block_framebuffer_writer_core #(
    parameter int STORE_COLUMNS = 150,
    parameter int STORE_ROWS    = 200
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // command channel
    input  logic                start,
    output logic                busy,
    input  gbfw_pkg::t_in_word  i_cmd,
    // result channel
    output logic                o_strobe,
    output gbfw_pkg::t_out_word o_result,
    // configuration channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [8:0]          i_cfg_data
);

    localparam int DEPTH = STORE_COLUMNS * STORE_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] COLS_A   = AW'(STORE_COLUMNS);
    localparam logic [AW-1:0] LAST_A   = AW'(DEPTH - 1);
    localparam logic [15:0]   COLS_16  = 16'(STORE_COLUMNS);
    localparam logic [15:0]   ROWS_16  = 16'(STORE_ROWS);

    // Sequencer states
    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_LOOK  = 2'd2;
    localparam logic [1:0] S_MOD   = 2'd3;

    logic [7:0] mem [DEPTH];

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic [AW-1:0]       r_clr_addr;
    logic [8:0]          r_panel_width;
    logic [8:0]          r_panel_height;
    gbfw_pkg::t_in_word  r_item;
    logic [AW-1:0]       r_addr;
    logic                r_ok;
    logic [7:0]          r_rd_data;
    logic                r_out_valid;
    gbfw_pkg::t_out_word r_out;

    logic                accept;
    logic                n_ok;
    logic [AW-1:0]       n_addr;
    logic [7:0]          row_sel;
    logic [7:0]          col_sel;
    logic                mem_we;
    logic [AW-1:0]       mem_wa;
    logic [7:0]          mem_wd;
    logic [7:0]          new_byte;
    gbfw_pkg::t_win_addr win;

    // Place one pixel's two gray bits in its block byte
    function automatic logic [7:0] put_gray(input logic [7:0] b, input logic sx,
                                            input logic sy, input logic [1:0] g);
        logic [2:0] pos;
        logic [2:0] hi;
        logic [2:0] lo;
        logic [7:0] res;
        pos = {sx, 1'b0, sy};
        hi  = 3'd7 - pos;
        lo  = 3'd5 - pos;
        res = b;
        res[hi] = g[1];
        res[lo] = g[0];
        return res;
    endfunction

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_out_valid;
    assign o_result    = r_out;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_panel_width  <= gbfw_pkg::PANEL_WIDTH_RST;
            r_panel_height <= gbfw_pkg::PANEL_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == gbfw_pkg::CFG_PANEL_WIDTH) begin
                r_panel_width <= i_cfg_data;
            end else if (i_cfg_index == gbfw_pkg::CFG_PANEL_HEIGHT) begin
                r_panel_height <= i_cfg_data;
            end
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == LAST_A) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) n_state = S_LOOK;
            end
            S_LOOK:  n_state = S_MOD;
            S_MOD:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // Command capture
    always_ff @(posedge i_clk) begin
        if (accept) r_item <= i_cmd;
    end

    // Clip and address for the lookup stage
    always_comb begin
        if (r_item.action == gbfw_pkg::ACT_WRITE) begin
            n_ok = !r_item.pos_x[15] && !r_item.pos_y[15]
                   && (16'(r_item.pos_x) < 16'(r_panel_width))
                   && (16'(r_item.pos_y) < 16'(r_panel_height))
                   && ({1'b0, r_item.pos_x[15:1]} < COLS_16)
                   && ({1'b0, r_item.pos_y[15:1]} < ROWS_16);
            row_sel = r_item.pos_y[8:1];
            col_sel = r_item.pos_x[8:1];
        end else begin
            n_ok = (r_item.action == gbfw_pkg::ACT_READ)
                   && (16'(r_item.read_row) < ROWS_16)
                   && (16'(r_item.read_column) < COLS_16);
            row_sel = r_item.read_row;
            col_sel = r_item.read_column;
        end
        n_addr = n_ok ? AW'(row_sel) * COLS_A + AW'(col_sel) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_LOOK) begin
            r_addr <= n_addr;
            r_ok   <= n_ok;
        end
    end

    // Memory write port: clearing sweep or pixel write-back
    always_comb begin
        new_byte = put_gray(r_rd_data, r_item.pos_x[0], r_item.pos_y[0], r_item.gray);
        mem_we   = (r_state == S_CLEAR)
                   || ((r_state == S_MOD) && r_ok
                       && (r_item.action == gbfw_pkg::ACT_WRITE));
        mem_wa   = (r_state == S_CLEAR) ? r_clr_addr : r_addr;
        mem_wd   = (r_state == S_CLEAR) ? 8'd0 : new_byte;
    end

    // Frame store
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rd_data <= mem[n_addr];
    end

    // Window addresses, computed alongside the lookup
    gbfw_window u_window (
        .i_clk  (i_clk),
        .i_load (r_state == S_LOOK),
        .i_item (r_item),
        .o_win  (win)
    );

    // Result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (r_state == S_MOD)
                           && ((r_item.action == gbfw_pkg::ACT_READ)
                               || (r_item.action == gbfw_pkg::ACT_WINDOW));
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_MOD) begin
            if (r_item.action == gbfw_pkg::ACT_WINDOW) begin
                r_out.read_data    <= 8'd0;
                r_out.window_valid <= win.valid;
                r_out.column_start <= win.column_start;
                r_out.column_end   <= win.column_end;
                r_out.row_start    <= win.row_start;
                r_out.row_end      <= win.row_end;
            end else begin
                r_out.read_data    <= r_ok ? r_rd_data : 8'd0;
                r_out.window_valid <= 1'b0;
                r_out.column_start <= 8'd0;
                r_out.column_end   <= 8'd0;
                r_out.row_start    <= 8'd0;
                r_out.row_end      <= 8'd0;
            end
        end
    end

endmodule
